FILE: hdl/uer_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by the controller, datapath and top level.
package uer_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int DIST_W      = 25;
   localparam int SUM_W       = 17;
   localparam int PROD_W      = 33;
   localparam int DIV_STEPS   = DIST_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   // Register reset values
   localparam logic [9:0]  TRIG_TICKS_RST     = 10'd10;
   localparam logic [7:0]  PRE_LOW_TICKS_RST  = 8'd2;
   localparam logic [15:0] WAIT_TIMEOUT_RST   = 16'd50000;
   localparam logic [14:0] MAX_PULSE_RST      = 15'd30000;
   localparam logic [7:0]  UNIT_TICKS_RST     = 8'd10;
   localparam logic [15:0] GAP_TICKS_RST      = 16'd10000;
   localparam logic [1:0]  ATTEMPT_COUNT_RST  = 2'd3;
   localparam logic [15:0] DISTANCE_SCALE_RST = 16'd4425;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRIG_TICKS     = 3'd0,
      CSR_PRE_LOW_TICKS  = 3'd1,
      CSR_WAIT_TIMEOUT   = 3'd2,
      CSR_MAX_PULSE      = 3'd3,
      CSR_UNIT_TICKS     = 3'd4,
      CSR_GAP_TICKS      = 3'd5,
      CSR_ATTEMPT_COUNT  = 3'd6,
      CSR_DISTANCE_SCALE = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_PRE  = 3'd1,
      PH_HIGH = 3'd2,
      PH_WAIT = 3'd3,
      PH_MEAS = 3'd4,
      PH_GAP  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUN = 2'd0,
      ST_MUL = 2'd1,
      ST_DIV = 2'd2,
      ST_OUT = 2'd3
   } ctl_state_type;

   typedef enum logic [1:0] {
      TICK_HOLD  = 2'd0,
      TICK_INC   = 2'd1,
      TICK_CLEAR = 2'd2
   } tick_op_type;

   typedef struct packed {
      logic kind;
      logic echo;
   } req_item_type;

   typedef struct packed {
      logic              trigger;
      logic              busy_res;
      logic              done_res;
      logic [DIST_W-1:0] distance_q8;
      logic [1:0]        valid_attempts;
   } rsp_item_type;

   typedef struct packed {
      logic        seq_clear;
      tick_op_type tick_op;
      logic        pulse_clear;
      logic        pulse_inc;
      logic        accumulate;
      logic        attempt_inc;
      logic        mul_load;
      logic        div_step;
      logic        out_load;
      logic        out_trig;
      logic        out_busy;
      logic        out_done;
   } dp_cmd_type;

   typedef struct packed {
      logic pre_done;
      logic high_done;
      logic wait_done;
      logic gap_done;
      logic unit_done;
      logic tick_zero;
      logic pulse_sat;
      logic last_attempt;
      logic limit_zero;
      logic div_last;
   } dp_status_type;

endpackage

FILE: hdl/uer_datapath.sv
`timescale 1ns / 1ps
// Datapath: registers, tick/unit counters, pulse sum, multiplier and
// bit-serial divider, result register. Uses uer_pkg.
module uer_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [uer_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [uer_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  uer_pkg::dp_cmd_type               cmd,
   output uer_pkg::dp_status_type            st,
   output uer_pkg::rsp_item_type             rsp_data
);
   import uer_pkg::*;

   logic [9:0]  trig_ticks_ff;
   logic [7:0]  pre_low_ticks_ff;
   logic [15:0] wait_timeout_ff;
   logic [14:0] max_pulse_ff;
   logic [7:0]  unit_ticks_ff;
   logic [15:0] gap_ticks_ff;
   logic [1:0]  attempt_count_ff;
   logic [15:0] distance_scale_ff;

   logic [15:0]      tick_count_ff;
   logic [14:0]      pulse_units_ff;
   logic [1:0]       attempt_ff;
   logic [1:0]       valid_total_ff;
   logic [SUM_W-1:0] pulse_sum_ff;

   logic [DIST_W-1:0]    quo_ff;
   logic [1:0]           rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   rsp_item_type         rsp_ff;

   logic [15:0]       tick_inc;
   logic [1:0]        attempt_inc;
   logic [PROD_W-1:0] prod;
   logic [2:0]        rem_shift;
   logic [2:0]        divisor;
   logic              div_fit;
   logic [2:0]        rem_diff;

   assign tick_inc    = tick_count_ff + 16'd1;
   assign attempt_inc = attempt_ff + 2'd1;
   assign prod        = PROD_W'(pulse_sum_ff) * PROD_W'(distance_scale_ff);
   assign rem_shift   = {rem_ff, quo_ff[DIST_W-1]};
   assign divisor     = {1'b0, valid_total_ff};
   assign div_fit     = rem_shift >= divisor;
   assign rem_diff    = rem_shift - divisor;

   always_comb begin
      st.pre_done     = tick_inc >= {8'd0, pre_low_ticks_ff};
      st.high_done    = tick_inc >= {6'd0, trig_ticks_ff};
      st.wait_done    = tick_inc >= wait_timeout_ff;
      st.gap_done     = tick_inc >= gap_ticks_ff;
      st.unit_done    = tick_inc >= {8'd0, unit_ticks_ff};
      st.tick_zero    = tick_count_ff == 16'd0;
      st.pulse_sat    = pulse_units_ff >= max_pulse_ff;
      // attempt_count cannot exceed three attempts, so it is the limit as is
      st.last_attempt = attempt_inc >= attempt_count_ff;
      st.limit_zero   = attempt_count_ff == 2'd0;
      st.div_last     = div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ticks_ff     <= TRIG_TICKS_RST;
         pre_low_ticks_ff  <= PRE_LOW_TICKS_RST;
         wait_timeout_ff   <= WAIT_TIMEOUT_RST;
         max_pulse_ff      <= MAX_PULSE_RST;
         unit_ticks_ff     <= UNIT_TICKS_RST;
         gap_ticks_ff      <= GAP_TICKS_RST;
         attempt_count_ff  <= ATTEMPT_COUNT_RST;
         distance_scale_ff <= DISTANCE_SCALE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TRIG_TICKS:     trig_ticks_ff     <= csr_wdata[9:0];
            CSR_PRE_LOW_TICKS:  pre_low_ticks_ff  <= csr_wdata[7:0];
            CSR_WAIT_TIMEOUT:   wait_timeout_ff   <= csr_wdata;
            CSR_MAX_PULSE:      max_pulse_ff      <= csr_wdata[14:0];
            CSR_UNIT_TICKS:     unit_ticks_ff     <= csr_wdata[7:0];
            CSR_GAP_TICKS:      gap_ticks_ff      <= csr_wdata;
            CSR_ATTEMPT_COUNT:  attempt_count_ff  <= csr_wdata[1:0];
            CSR_DISTANCE_SCALE: distance_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Measurement sequence state
   always_ff @(posedge clock) begin
      if (reset || cmd.seq_clear) begin
         tick_count_ff  <= '0;
         pulse_units_ff <= '0;
         attempt_ff     <= '0;
         valid_total_ff <= '0;
         pulse_sum_ff   <= '0;
      end else begin
         unique case (cmd.tick_op)
            TICK_INC:   tick_count_ff <= tick_inc;
            TICK_CLEAR: tick_count_ff <= '0;
            default:    tick_count_ff <= tick_count_ff;
         endcase
         if (cmd.pulse_clear) begin
            pulse_units_ff <= '0;
         end else if (cmd.pulse_inc) begin
            pulse_units_ff <= pulse_units_ff + 15'd1;
         end
         if (cmd.attempt_inc) begin
            attempt_ff <= attempt_inc;
         end
         if (cmd.accumulate) begin
            pulse_sum_ff   <= pulse_sum_ff + {2'd0, pulse_units_ff};
            valid_total_ff <= valid_total_ff + 2'd1;
         end
      end
   end

   // Scaled sum, then restoring division by the valid count, one bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         quo_ff     <= prod[PROD_W-1:8];
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff     <= {quo_ff[DIST_W-2:0], div_fit};
         rem_ff     <= div_fit ? rem_diff[1:0] : rem_shift[1:0];
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.trigger  <= cmd.out_trig;
         rsp_ff.busy_res <= cmd.out_busy;
         rsp_ff.done_res <= cmd.out_done;
         if (cmd.out_done && valid_total_ff != 2'd0) begin
            rsp_ff.distance_q8 <= quo_ff;
         end else begin
            rsp_ff.distance_q8 <= '0;
         end
         rsp_ff.valid_attempts <= cmd.out_done ? valid_total_ff : 2'd0;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hdl/uer_controller.sv
`timescale 1ns / 1ps
// Controller: measurement phase machine, result compute sequencing and
// both channel handshakes. Uses uer_pkg.
module uer_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  uer_pkg::req_item_type   req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  uer_pkg::dp_status_type  st,
   output uer_pkg::dp_cmd_type     cmd
);
   import uer_pkg::*;

   phase_type     phase_ff, phase_in;
   ctl_state_type ctl_ff, ctl_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic accept;
   logic next_att;
   logic done_now;
   logic meas_end;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (ctl_ff != ST_RUN) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign meas_end  = st.tick_zero && (!req_data.echo || st.pulse_sat);

   always_comb begin
      next_att = 1'b0;
      unique case (phase_ff)
         PH_WAIT: next_att = !req_data.echo && st.wait_done;
         PH_GAP:  next_att = st.gap_done;
         default: next_att = 1'b0;
      endcase
      if (req_data.kind) begin
         done_now = (phase_ff == PH_IDLE) && st.limit_zero;
      end else begin
         done_now = next_att && st.last_attempt;
      end
   end

   // Next state
   always_comb begin
      phase_in = phase_ff;
      ctl_in   = ctl_ff;
      unique case (ctl_ff)
         ST_RUN:  if (accept && done_now) ctl_in = ST_MUL;
         ST_MUL:  ctl_in = ST_DIV;
         ST_DIV:  if (st.div_last) ctl_in = ST_OUT;
         // hold the finished item until the result register is free
         ST_OUT:  if (out_free) ctl_in = ST_RUN;
         default: ctl_in = ST_RUN;
      endcase
      if (accept) begin
         if (req_data.kind) begin
            if (phase_ff == PH_IDLE && !st.limit_zero) phase_in = PH_PRE;
         end else begin
            unique case (phase_ff)
               PH_IDLE: phase_in = PH_IDLE;
               PH_PRE:  if (st.pre_done) phase_in = PH_HIGH;
               PH_HIGH: if (st.high_done) phase_in = PH_WAIT;
               PH_WAIT: begin
                  if (req_data.echo) begin
                     phase_in = PH_MEAS;
                  end else if (st.wait_done) begin
                     phase_in = st.last_attempt ? PH_IDLE : PH_PRE;
                  end
               end
               PH_MEAS: if (meas_end) phase_in = PH_GAP;
               PH_GAP: begin
                  if (st.gap_done) phase_in = st.last_attempt ? PH_IDLE : PH_PRE;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Datapath commands
   always_comb begin
      cmd         = '0;
      cmd.tick_op = TICK_HOLD;
      unique case (ctl_ff)
         ST_MUL: cmd.mul_load = 1'b1;
         ST_DIV: cmd.div_step = 1'b1;
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_done = 1'b1;
            end
         end
         default: begin
            // done items wait for the divider; all others answer at once
            if (accept && !done_now) begin
               cmd.out_load = 1'b1;
               cmd.out_trig = !req_data.kind && (phase_ff == PH_HIGH);
               cmd.out_busy = phase_in != PH_IDLE;
            end
         end
      endcase
      if (accept) begin
         if (req_data.kind) begin
            cmd.seq_clear = phase_ff == PH_IDLE;
         end else begin
            unique case (phase_ff)
               PH_PRE:  cmd.tick_op = st.pre_done ? TICK_CLEAR : TICK_INC;
               PH_HIGH: cmd.tick_op = st.high_done ? TICK_CLEAR : TICK_INC;
               PH_WAIT: begin
                  if (req_data.echo) begin
                     cmd.tick_op     = TICK_CLEAR;
                     cmd.pulse_clear = 1'b1;
                  end else if (st.wait_done) begin
                     cmd.tick_op     = TICK_CLEAR;
                     cmd.pulse_clear = 1'b1;
                     cmd.attempt_inc = 1'b1;
                  end else begin
                     cmd.tick_op = TICK_INC;
                  end
               end
               PH_MEAS: begin
                  if (meas_end) begin
                     cmd.accumulate = 1'b1;
                     cmd.tick_op    = TICK_CLEAR;
                  end else begin
                     cmd.pulse_inc = st.tick_zero;
                     cmd.tick_op   = st.unit_done ? TICK_CLEAR : TICK_INC;
                  end
               end
               PH_GAP: begin
                  if (st.gap_done) begin
                     cmd.tick_op     = TICK_CLEAR;
                     cmd.pulse_clear = 1'b1;
                     cmd.attempt_inc = 1'b1;
                  end else begin
                     cmd.tick_op = TICK_INC;
                  end
               end
               default: cmd.tick_op = TICK_HOLD;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         ctl_ff       <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/ultrasonic_echo_ranger_unit.sv
`timescale 1ns / 1ps
// Ultrasonic echo ranger top level. Each req item is one timebase tick or a start.
// An item that does not end a sequence is answered from the result register; the item
// that ends it passes a multiply step, 25 divider steps and a load step first.
// Throughput: one item per cycle while the result side does not stall, except behind a finishing item (divider bound).
// Reset (synchronous, active high) clears the sequence state, restores register defaults.
module ultrasonic_echo_ranger_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  uer_pkg::req_item_type            req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output uer_pkg::rsp_item_type            rsp_data,
   input  logic                             csr_wr_en,
   input  logic [uer_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [uer_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import uer_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type st;

   uer_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .cmd       (cmd)
   );

   uer_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .st        (st),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // a finished sequence is never reported as still running
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res && !rsp_data.trigger)
      else $error("done item reports busy or trigger");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |->
         rsp_data.distance_q8 == '0 && rsp_data.valid_attempts == 2'd0)
      else $error("result fields set on an item that is not done");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res && rsp_data.valid_attempts == 2'd0 |->
         rsp_data.distance_q8 == '0)
      else $error("distance reported with no valid attempt");

   // while the divider runs no item may enter
   assert property (@(posedge clock) disable iff (reset)
      cmd.mul_load || cmd.div_step |-> req_stall && !cmd.seq_clear)
      else $error("item accepted during result computation");
`endif

endmodule

FILE: tb/ultrasonic_echo_ranger_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for ultrasonic_echo_ranger_unit: an item-level ranger model
// predicts one result per accepted tick or start item. Depends on uer_pkg and the RTL.
module ultrasonic_echo_ranger_unit_tb;
   import uer_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PHASES  = 9;
   localparam int PHASE_ITEMS    = 24;
   localparam int SETTLE_CYCLES  = 40;
   // echo levels of the ticks that walk the zero-limit sequence, first tick in the MSB
   localparam logic [12:0] ZERO_LIMIT_ECHO = 13'b0010000000110;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_item_type  req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_item_type  rsp_data;
   logic          csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_TRIG_TICKS;
   logic [15:0]   csr_wdata = '0;

   ultrasonic_echo_ranger_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ranger register copy
   logic [9:0]  cfg_trig      = TRIG_TICKS_RST;
   logic [7:0]  cfg_pre       = PRE_LOW_TICKS_RST;
   logic [15:0] cfg_timeout   = WAIT_TIMEOUT_RST;
   logic [14:0] cfg_max_units = MAX_PULSE_RST;
   logic [7:0]  cfg_unit      = UNIT_TICKS_RST;
   logic [15:0] cfg_gap       = GAP_TICKS_RST;
   logic [1:0]  cfg_attempts  = ATTEMPT_COUNT_RST;
   logic [15:0] cfg_scale     = DISTANCE_SCALE_RST;

   // ranger sequence state
   phase_type   seq_phase   = PH_IDLE;
   logic [15:0] tick_cnt    = '0;
   logic [14:0] units       = '0;
   logic [1:0]  attempt_idx = '0;
   logic [1:0]  valid_cnt   = '0;
   logic [16:0] unit_sum    = '0;

   req_item_type tick_items[$];
   rsp_item_type echo_reports[$];
   int           queued;
   int           idle_mode = 0;
   int           failures = 0;
   int           quiet_cycles = 0;

   function automatic bit next_attempt();
      attempt_idx++;
      tick_cnt = '0;
      units = '0;
      if (attempt_idx >= cfg_attempts) begin
         seq_phase = PH_IDLE;
         return 1'b1;
      end
      seq_phase = PH_PRE;
      return 1'b0;
   endfunction

   function automatic rsp_item_type advance_ranger(req_item_type it);
      rsp_item_type     r;
      logic             fin;
      logic             trig;
      longint unsigned  avg_dist;
      r = '0;
      fin = 1'b0;
      trig = 1'b0;
      if (it.kind) begin
         // a start while busy is ignored
         if (seq_phase == PH_IDLE) begin
            tick_cnt = '0;
            units = '0;
            attempt_idx = '0;
            valid_cnt = '0;
            unit_sum = '0;
            if (cfg_attempts == 0) fin = 1'b1;
            else seq_phase = PH_PRE;
         end
      end else begin
         case (seq_phase)
            PH_PRE: begin
               tick_cnt++;
               if (tick_cnt >= cfg_pre) begin
                  seq_phase = PH_HIGH;
                  tick_cnt = '0;
               end
            end
            PH_HIGH: begin
               trig = 1'b1;
               tick_cnt++;
               if (tick_cnt >= cfg_trig) begin
                  seq_phase = PH_WAIT;
                  tick_cnt = '0;
               end
            end
            PH_WAIT: begin
               if (it.echo) begin
                  seq_phase = PH_MEAS;
                  tick_cnt = '0;
                  units = '0;
               end else begin
                  tick_cnt++;
                  if (tick_cnt >= cfg_timeout) fin = next_attempt();
               end
            end
            PH_MEAS: begin
               // echo only matters on unit boundaries
               if (tick_cnt == 0 && (!it.echo || units >= cfg_max_units)) begin
                  unit_sum = unit_sum + units;
                  valid_cnt++;
                  seq_phase = PH_GAP;
                  tick_cnt = '0;
               end else begin
                  if (tick_cnt == 0) units++;
                  tick_cnt++;
                  if (tick_cnt >= cfg_unit) tick_cnt = '0;
               end
            end
            PH_GAP: begin
               tick_cnt++;
               if (tick_cnt >= cfg_gap) fin = next_attempt();
            end
            default: seq_phase = PH_IDLE;
         endcase
      end
      r.trigger = trig;
      r.busy_res = (seq_phase != PH_IDLE);
      r.done_res = fin;
      if (fin && valid_cnt != 0) begin
         avg_dist = (64'(unit_sum) * 64'(cfg_scale)) >> 8;
         avg_dist = avg_dist / valid_cnt;
         r.distance_q8 = avg_dist[DIST_W-1:0];
      end
      if (fin) r.valid_attempts = valid_cnt;
      return r;
   endfunction

   function automatic void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   function automatic int at_least_one(int v);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic bit holds_off(int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) echo_reports.push_back(advance_ranger(req_data));
         if (!req_valid || !req_stall) begin
            if (tick_items.size() != 0 &&
                !holds_off(idle_mode == 0 ? 14 : idle_mode == 1 ? 62 : 0)) begin
               req_valid <= 1'b1;
               req_data <= tick_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (echo_reports.size() == 0) begin
               $error("result item with nothing expected");
               failures++;
            end else begin
               want = echo_reports.pop_front();
               check_field("trigger", want.trigger, rsp_data.trigger);
               check_field("busy_res", want.busy_res, rsp_data.busy_res);
               check_field("done_res", want.done_res, rsp_data.done_res);
               check_field("distance_q8", want.distance_q8, rsp_data.distance_q8);
               check_field("valid_attempts", want.valid_attempts, rsp_data.valid_attempts);
            end
         end
         rsp_stall <= holds_off(idle_mode == 0 ? 62 : idle_mode == 1 ? 14 : 0);
      end
   end

   // watchdog: cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void push_item(bit kind, bit echo);
      req_item_type it;
      it.kind = kind;
      it.echo = echo;
      tick_items.push_back(it);
      queued++;
   endfunction

   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic set_config(logic [9:0] trig, logic [7:0] pre, logic [15:0] tmo,
                             logic [14:0] maxu, logic [7:0] unit_t, logic [15:0] gap,
                             logic [1:0] att, logic [15:0] scale);
      write_reg(CSR_TRIG_TICKS, 16'(trig));
      write_reg(CSR_PRE_LOW_TICKS, 16'(pre));
      write_reg(CSR_WAIT_TIMEOUT, tmo);
      write_reg(CSR_MAX_PULSE, 16'(maxu));
      write_reg(CSR_UNIT_TICKS, 16'(unit_t));
      write_reg(CSR_GAP_TICKS, gap);
      write_reg(CSR_ATTEMPT_COUNT, 16'(att));
      write_reg(CSR_DISTANCE_SCALE, scale);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      // nothing is in flight, so the model copy can follow right away
      cfg_trig = trig;
      cfg_pre = pre;
      cfg_timeout = tmo;
      cfg_max_units = maxu;
      cfg_unit = unit_t;
      cfg_gap = gap;
      cfg_attempts = att;
      cfg_scale = scale;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (tick_items.size() != 0 || req_valid || echo_reports.size() != 0);
   endtask

   task automatic random_config();
      int          sel;
      logic [15:0] scale;
      sel = $urandom_range(0, 3);
      scale = (sel == 0) ? 16'hFFFF : (sel == 1) ? 16'h0000 : 16'($urandom);
      sel = $urandom_range(0, 7);
      if ($urandom_range(0, 7) == 0)
         set_config(10'($urandom_range(0, 40)), 8'($urandom_range(0, 20)),
                    16'($urandom_range(0, 200)), 15'($urandom_range(0, 200)),
                    8'($urandom_range(0, 8)), 16'($urandom_range(0, 100)),
                    (sel == 0) ? 2'd0 : 2'(sel % 3 + 1), scale);
      else
         set_config(10'($urandom_range(0, 4)), 8'($urandom_range(0, 3)),
                    16'($urandom_range(0, 12)), 15'($urandom_range(0, 15)),
                    8'($urandom_range(0, 3)), 16'($urandom_range(0, 6)),
                    (sel == 0) ? 2'd0 : 2'(sel % 3 + 1), scale);
   endtask

   // one start plus the ticks of a well-formed sequence, with a little noise
   task automatic queue_measurement();
      int tmo;
      int lead;
      int pulse_len;
      int unit_len;
      tmo = int'(cfg_timeout);
      unit_len = at_least_one(int'(cfg_unit));
      push_item(1'b1, 1'($urandom));
      for (int a = 0; a < int'(cfg_attempts); a++) begin
         repeat (at_least_one(int'(cfg_pre)) + at_least_one(int'(cfg_trig))) begin
            if ($urandom_range(0, 15) == 0) push_item(1'b1, 1'($urandom));
            else push_item(1'b0, $urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 3) == 0) begin
            repeat (at_least_one(tmo)) push_item(1'b0, 1'b0);
         end else begin
            lead = (tmo <= 1) ? 0 : $urandom_range(0, (tmo - 1 < 8) ? tmo - 1 : 8);
            repeat (lead) push_item(1'b0, 1'b0);
            pulse_len = $urandom_range(1, (int'(cfg_max_units) + 2 < 24) ?
                                          int'(cfg_max_units) + 2 : 24);
            repeat (pulse_len * unit_len) push_item(1'b0, 1'b1);
            repeat (unit_len + at_least_one(int'(cfg_gap)) + $urandom_range(0, 1))
               push_item(1'b0, 1'b0);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // idle ticks, then a start and a start while busy, at reset settings
      push_item(1'b0, 1'b0);
      push_item(1'b0, 1'b1);
      push_item(1'b1, 1'b0);
      push_item(1'b1, 1'b1);
      wait_drained();

      // all limits zero, written mid-sequence
      set_config(10'd0, 8'd0, 16'd0, 15'd0, 8'd0, 16'd0, 2'd3, 16'hFFFF);
      push_item(1'b1, 1'b0);
      for (int i = 12; i >= 0; i--) push_item(1'b0, ZERO_LIMIT_ECHO[i]);
      wait_drained();

      // zero attempts ends on the start item
      set_config(10'd0, 8'd0, 16'd0, 15'd0, 8'd0, 16'd0, 2'd0, 16'd0);
      push_item(1'b1, 1'b1);
      push_item(1'b0, 1'b1);
      wait_drained();

      // top of every range; stop while the trigger is still high
      set_config(10'd1023, 8'd255, 16'hFFFF, 15'h7FFF, 8'd255, 16'hFFFF, 2'd3, 16'hFFFF);
      push_item(1'b1, 1'b0);
      repeat (270) push_item(1'b0, 1'($urandom));
      wait_drained();

      // shorten the trigger mid-pulse, then a long unit count; stop inside the gap
      set_config(10'd1, 8'd0, 16'hFFFF, 15'h7FFF, 8'd255, 16'hFFFF, 2'd3, 16'hFFFF);
      push_item(1'b0, 1'b0);
      repeat (5) push_item(1'b0, 1'b0);
      repeat (2 * 255 + 1) push_item(1'b0, 1'b1);
      repeat (10) push_item(1'b0, 1'b0);
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         idle_mode = ph * 3 / RANDOM_PHASES;
         random_config();
         queued = 0;
         while (queued < PHASE_ITEMS) begin
            queue_measurement();
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 4)) push_item(1'($urandom), 1'($urandom));
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: sim.f
hdl/uer_pkg.sv
hdl/uer_datapath.sv
hdl/uer_controller.sv
hdl/ultrasonic_echo_ranger_unit.sv
tb/ultrasonic_echo_ranger_unit_tb.sv
